// File: rtl/ft_sensor_record_tracker_core_macros.svh
// Assertion macros used by the port-level checker of the tracker core.
// Depends on nothing; expects signals clk and arst_n in the using scope.
`ifndef FT_SENSOR_RECORD_TRACKER_CORE_MACROS_SVH
`define FT_SENSOR_RECORD_TRACKER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FT_SRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FT_SRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ft_srt_pkg.sv
// Types and constants of the force/torque record tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ft_srt_pkg;

	localparam int WORD_W = 32;
	localparam int AXIS_W = 48;
	localparam int AXES   = 6;

	localparam logic [WORD_W-1:0] SCALE_RESET = 32'd4295;

	typedef enum logic {
		REG_FORCE_SCALE  = 1'b0,
		REG_TORQUE_SCALE = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		OUTCOME_ACCEPTED   = 2'd0,
		OUTCOME_STALE      = 2'd1,
		OUTCOME_WRONG_SIZE = 2'd2
	} outcome_t;

	typedef struct packed {
		outcome_t outcome;
		logic     take;
	} verdict_t;

endpackage

// File: rtl/ft_srt_scale.sv
// One axis scaler: (signed count * unsigned Q0.32 scale) >> 16, floor.
// Depends on ft_srt_pkg.
`timescale 1ns / 1ps

module ft_srt_scale (
	input  logic signed [31:0] raw,
	input  logic        [31:0] scale,
	output logic signed [47:0] value
);
	import ft_srt_pkg::*;

	logic signed [WORD_W*2:0] prod;

	assign prod  = raw * $signed({1'b0, scale});
	assign value = prod[AXIS_W+15:16];

endmodule

// File: rtl/ft_srt_track.sv
// Sequence tracking, status latch and saturating counters.
// Depends on ft_srt_pkg; gives the verdict that steers the axis registers.
`timescale 1ns / 1ps

module ft_srt_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  length_ok,
	input  logic [31:0]           record_status,
	input  logic [31:0]           sequence_req,
	output ft_srt_pkg::verdict_t  verdict,
	output logic [31:0]           latched_status,
	output logic [31:0]           lost_total,
	output logic [31:0]           accepted_total,
	output logic [31:0]           stale_total
);
	import ft_srt_pkg::*;

	logic [WORD_W-1:0] last_seq_q;
	logic [WORD_W-1:0] status_q;
	logic [WORD_W-1:0] lost_q;
	logic [WORD_W-1:0] accepted_q;
	logic [WORD_W-1:0] stale_q;
	logic [WORD_W-1:0] diff;
	logic [WORD_W:0]   lost_sum;
	logic [WORD_W-1:0] lost_next;
	logic [WORD_W-1:0] accepted_next;
	logic [WORD_W-1:0] stale_next;
	logic              take;

	assign diff     = sequence_req - last_seq_q;
	assign take     = length_ok && (diff != '0) && !diff[WORD_W-1];
	assign lost_sum = {1'b0, lost_q} + {1'b0, diff - 32'd1};

	assign lost_next     = lost_sum[WORD_W] ? '1 : lost_sum[WORD_W-1:0];
	assign accepted_next = (&accepted_q) ? accepted_q : accepted_q + 32'd1;
	assign stale_next    = (&stale_q) ? stale_q : stale_q + 32'd1;

	always_comb begin
		verdict.take = take;
		priority if (!length_ok) begin
			verdict.outcome = OUTCOME_WRONG_SIZE;
		end else if (take) begin
			verdict.outcome = OUTCOME_ACCEPTED;
		end else begin
			verdict.outcome = OUTCOME_STALE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q <= '0;
			status_q   <= '0;
			lost_q     <= '0;
			accepted_q <= '0;
			stale_q    <= '0;
		end else if (load && length_ok) begin
			last_seq_q <= sequence_req;
			if (record_status != '0) begin
				status_q <= record_status;
			end
			if (take) begin
				lost_q     <= lost_next;
				accepted_q <= accepted_next;
			end else begin
				stale_q <= stale_next;
			end
		end
	end

	assign latched_status = status_q;
	assign lost_total     = lost_q;
	assign accepted_total = accepted_q;
	assign stale_total    = stale_q;

endmodule

// File: rtl/ft_sensor_record_tracker_core.sv
// Force/torque record tracker: top level with beat registers and axis store.
// Depends on ft_srt_pkg, ft_srt_scale and ft_srt_track.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one unpacked sensor record
//   per beat; output channel (out_valid / out_stall) carries one result beat
//   per record: outcome plus the stored axes, status latch and counters as
//   they stand after that record.
//   A beat passes through the input register, then the result register; one
//   record per cycle is taken, and throughput is one beat per cycle, while
//   the output is not stalled. Sequence and counters update per record.
//   Scale registers are written through wr_en / wr_index / wr_data; the user
//   must do so only while no record is in flight (the block does not enforce it).
//   Reset clears all counters, the status latch, the last sequence and the
//   axis store, and loads both scales with 4295.
//   While the receiver stalls, the result beat and all its fields hold; one
//   more record waits in the input register, then in_stall rises.
`timescale 1ns / 1ps

module ft_sensor_record_tracker_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  ft_srt_pkg::reg_index_t wr_index,
	input  logic [31:0]           wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  length_ok,
	input  logic [31:0]           record_status,
	input  logic [31:0]           sequence_req,
	input  logic signed [31:0]    raw_fx,
	input  logic signed [31:0]    raw_fy,
	input  logic signed [31:0]    raw_fz,
	input  logic signed [31:0]    raw_tx,
	input  logic signed [31:0]    raw_ty,
	input  logic signed [31:0]    raw_tz,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ft_srt_pkg::outcome_t  outcome,
	output logic signed [47:0]    force_x,
	output logic signed [47:0]    force_y,
	output logic signed [47:0]    force_z,
	output logic signed [47:0]    torque_x,
	output logic signed [47:0]    torque_y,
	output logic signed [47:0]    torque_z,
	output logic [31:0]           latched_status,
	output logic [31:0]           lost_total,
	output logic [31:0]           accepted_total,
	output logic [31:0]           stale_total
);
	import ft_srt_pkg::*;

	logic              valid_s1;
	logic              length_ok_s1;
	logic [WORD_W-1:0] status_s1;
	logic [WORD_W-1:0] seq_s1;
	logic signed [WORD_W-1:0] raw_s1 [AXES];
	logic signed [AXIS_W-1:0] scaled [AXES];
	logic signed [AXIS_W-1:0] axis_q [AXES];
	logic [WORD_W-1:0] force_scale_q;
	logic [WORD_W-1:0] torque_scale_q;
	logic              out_valid_q;
	outcome_t          outcome_q;
	logic              out_free;
	logic              advance;
	verdict_t          verdict;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_scale_q  <= SCALE_RESET;
			torque_scale_q <= SCALE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FORCE_SCALE:  force_scale_q  <= wr_data;
				REG_TORQUE_SCALE: torque_scale_q <= wr_data;
				default:          force_scale_q  <= force_scale_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			length_ok_s1 <= length_ok;
			status_s1    <= record_status;
			seq_s1       <= sequence_req;
			raw_s1[0]    <= raw_fx;
			raw_s1[1]    <= raw_fy;
			raw_s1[2]    <= raw_fz;
			raw_s1[3]    <= raw_tx;
			raw_s1[4]    <= raw_ty;
			raw_s1[5]    <= raw_tz;
		end
	end

	for (genvar i = 0; i < AXES; i++) begin : g_axis
		ft_srt_scale u_scale (
			.raw   (raw_s1[i]),
			.scale ((i < AXES / 2) ? force_scale_q : torque_scale_q),
			.value (scaled[i])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				axis_q[i] <= '0;
			end else if (advance && verdict.take) begin
				axis_q[i] <= scaled[i];
			end
		end
	end

	ft_srt_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance),
		.length_ok      (length_ok_s1),
		.record_status  (status_s1),
		.sequence_req   (seq_s1),
		.verdict        (verdict),
		.latched_status (latched_status),
		.lost_total     (lost_total),
		.accepted_total (accepted_total),
		.stale_total    (stale_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_q <= verdict.outcome;
		end
	end

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;
	assign force_x   = axis_q[0];
	assign force_y   = axis_q[1];
	assign force_z   = axis_q[2];
	assign torque_x  = axis_q[3];
	assign torque_y  = axis_q[4];
	assign torque_z  = axis_q[5];

endmodule

// File: rtl/ft_srt_checker.sv
// Port-level checks of the tracker core, bound to the top level.
// Depends on ft_srt_pkg and ft_sensor_record_tracker_core_macros.svh.
`timescale 1ns / 1ps
`include "ft_sensor_record_tracker_core_macros.svh"

module ft_srt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  outcome,
	input logic [31:0] accepted_total,
	input logic [31:0] stale_total
);
	import ft_srt_pkg::*;

	`FT_SRT_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(outcome), "result beat changed while stalled")
	`FT_SRT_ASSERT_NEXT(a_accepted_mono, 1'b1, accepted_total >= $past(accepted_total), "accepted count went down")
	`FT_SRT_ASSERT_NOW(a_accepted_seen, out_valid && (outcome == OUTCOME_ACCEPTED), accepted_total != '0, "accepted beat with zero accepted count")
	`FT_SRT_ASSERT_NOW(a_stale_seen, out_valid && (outcome == OUTCOME_STALE), stale_total != '0, "stale beat with zero stale count")

endmodule

bind ft_sensor_record_tracker_core ft_srt_checker u_checker (.*);
